FILE: rtl/core/ptsched_pkg.sv
// shared constants, codes and controller/datapath types of the periodic task scheduler
`default_nettype none

package ptsched_pkg;

	localparam int NUM_TASKS     = 8;
	localparam int TIME_BITS     = 32;
	localparam int INTERVAL_BITS = 16;
	localparam int MAX_OUT       = 8;
	localparam int USED_MAX      = (NUM_TASKS < MAX_OUT) ? NUM_TASKS : MAX_OUT;
	localparam int IDX_BITS      = $clog2(NUM_TASKS);

	localparam int ACTION_BITS  = 2;
	localparam int SLOT_BITS    = 3;
	localparam int COUNT_BITS   = 4;
	localparam int TASK_ID_BITS = 3;
	localparam int STATUS_BITS  = 2;

	typedef enum logic [ACTION_BITS-1:0] {
		ACT_TICK,
		ACT_LOAD,
		ACT_START,
		ACT_STOP
	} action_t;

	typedef enum logic [STATUS_BITS-1:0] {
		STS_OK,
		STS_ZERO_IVL,
		STS_STOPPED
	} status_t;

	typedef logic [IDX_BITS-1:0] idx_t;
	typedef logic [NUM_TASKS-1:0] mask_t;

	typedef struct packed {
		logic accept;
		logic scan;
		idx_t idx;
		logic push;
	} cmd_t;

	typedef struct packed {
		logic running;
		logic out_free;
		logic mask_empty;
		logic mask_last;
		idx_t idx_last;
	} sts_t;

endpackage

`default_nettype wire

FILE: rtl/core/ptsched_req_if.sv
// request channel: action, slot and interval words
`default_nettype none

interface ptsched_req_if;
	logic                                  valid;
	logic                                  ready;
	logic [ptsched_pkg::ACTION_BITS-1:0]   action;
	logic [ptsched_pkg::SLOT_BITS-1:0]     slot;
	logic [ptsched_pkg::INTERVAL_BITS-1:0] interval;

	modport source (output valid, action, slot, interval, input ready);
	modport sink (input valid, action, slot, interval, output ready);
endinterface

`default_nettype wire

FILE: rtl/core/ptsched_rsp_if.sv
// response channel: fired task words
`default_nettype none

interface ptsched_rsp_if;
	logic                                 valid;
	logic                                 ready;
	logic [ptsched_pkg::TASK_ID_BITS-1:0] task_id;
	logic                                 fired;
	logic                                 last;
	logic [ptsched_pkg::STATUS_BITS-1:0]  status;

	modport source (output valid, task_id, fired, last, status, input ready);
	modport sink (input valid, task_id, fired, last, status, output ready);
endinterface

`default_nettype wire

FILE: rtl/core/ptsched_cfg_if.sv
// configuration write channel: active slot count word
`default_nettype none

interface ptsched_cfg_if;
	logic                               valid;
	logic                               ready;
	logic [ptsched_pkg::COUNT_BITS-1:0] data;

	modport source (output valid, data, input ready);
	modport sink (input valid, data, output ready);
endinterface

`default_nettype wire

FILE: rtl/core/ptsched_ctrl.sv
// controller state machine: accept, slot scan and result emission sequencing
`default_nettype none

module ptsched_ctrl (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                in_valid,
	input  wire logic [ptsched_pkg::ACTION_BITS-1:0] in_action,
	output logic                                     in_ready,
	output ptsched_pkg::cmd_t                        cmd,
	input  wire ptsched_pkg::sts_t                   sts
);
	import ptsched_pkg::*;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_EMIT
	} state_t;

	state_t state_q;
	idx_t   idx_q;
	logic   accept;

	assign in_ready   = (state_q == ST_IDLE);
	assign accept     = in_valid && in_ready;
	assign cmd.accept = accept;
	assign cmd.scan   = (state_q == ST_SCAN);
	assign cmd.idx    = idx_q;
	assign cmd.push   = (state_q == ST_EMIT) && sts.out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			idx_q   <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						idx_q <= '0;
						if (in_action == ACT_TICK && sts.running)
							state_q <= ST_SCAN;
						else
							state_q <= ST_EMIT;
					end
				end
				ST_SCAN: begin
					if (idx_q == sts.idx_last)
						state_q <= ST_EMIT;
					else
						idx_q <= idx_q + idx_t'(1);
				end
				ST_EMIT: begin
					if (sts.out_free && (sts.mask_empty || sts.mask_last))
						state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> state_q != ST_IDLE)
		else $error("accepted word left controller idle");

	a_emit_done: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_EMIT && sts.out_free && (sts.mask_empty || sts.mask_last)
		|=> state_q == ST_IDLE)
		else $error("final result did not return controller to idle");

	a_scan_end: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_SCAN && idx_q == sts.idx_last |=> state_q == ST_EMIT)
		else $error("scan overran last active slot");

endmodule

`default_nettype wire

FILE: rtl/core/ptsched_dp.sv
// datapath: time counter, slot tables, due mask and output register
`default_nettype none

module ptsched_dp (
	input  wire logic                                  clk,
	input  wire logic                                  arst_n,
	input  wire ptsched_pkg::cmd_t                     cmd,
	output ptsched_pkg::sts_t                          sts,
	input  wire logic [ptsched_pkg::ACTION_BITS-1:0]   in_action,
	input  wire logic [ptsched_pkg::SLOT_BITS-1:0]     in_slot,
	input  wire logic [ptsched_pkg::INTERVAL_BITS-1:0] in_interval,
	input  wire logic                                  cfg_valid,
	output logic                                       cfg_ready,
	input  wire logic [ptsched_pkg::COUNT_BITS-1:0]    cfg_data,
	output logic                                       out_valid,
	input  wire logic                                  out_ready,
	output logic [ptsched_pkg::TASK_ID_BITS-1:0]       task_id,
	output logic                                       fired,
	output logic                                       last,
	output logic [ptsched_pkg::STATUS_BITS-1:0]        status
);
	import ptsched_pkg::*;

	logic [COUNT_BITS-1:0]    active_count_q;
	logic                     running_q;
	logic [TIME_BITS-1:0]     time_q;
	logic [INTERVAL_BITS-1:0] ivl_q [NUM_TASKS];
	logic [TIME_BITS-1:0]     due_q [NUM_TASKS];
	mask_t                    mask_q;
	status_t                  status_q;

	logic                     out_valid_q;
	idx_t                     task_id_q;
	logic                     fired_q;
	logic                     last_q;
	status_t                  out_status_q;

	logic [COUNT_BITS-1:0]    n_slots;
	mask_t                    act;
	logic                     start_bad;
	logic                     start_ok;
	logic                     tick_run;
	logic [TIME_BITS-1:0]     diff;
	logic                     is_due;
	idx_t                     lo_idx;
	logic                     mask_empty;
	logic                     mask_last;

	// active count clamped to the usable slot range
	always_comb begin
		if (active_count_q == '0)
			n_slots = COUNT_BITS'(1);
		else if (active_count_q > COUNT_BITS'(USED_MAX))
			n_slots = COUNT_BITS'(USED_MAX);
		else
			n_slots = active_count_q;
	end

	always_comb begin
		act       = '0;
		start_bad = 1'b0;
		for (int s = 0; s < NUM_TASKS; s++) begin
			act[s] = (COUNT_BITS'(s) < n_slots);
			if (act[s] && ivl_q[s] == '0)
				start_bad = 1'b1;
		end
	end

	assign start_ok = cmd.accept && in_action == ACT_START && !start_bad;
	assign tick_run = cmd.accept && in_action == ACT_TICK && running_q;

	// wrap-safe due test on the scanned slot
	assign diff   = time_q - due_q[cmd.idx];
	assign is_due = !diff[TIME_BITS-1];

	// lowest pending slot
	always_comb begin
		lo_idx = '0;
		for (int s = NUM_TASKS - 1; s >= 0; s--) begin
			if (mask_q[s])
				lo_idx = idx_t'(s);
		end
	end

	assign mask_empty = (mask_q == '0);
	assign mask_last  = ((mask_q & (mask_q - mask_t'(1))) == '0);

	assign sts.running    = running_q;
	assign sts.out_free   = !out_valid_q || out_ready;
	assign sts.mask_empty = mask_empty;
	assign sts.mask_last  = mask_last;
	assign sts.idx_last   = idx_t'(n_slots - COUNT_BITS'(1));

	assign cfg_ready = 1'b1;
	assign out_valid = out_valid_q;
	assign task_id   = task_id_q;
	assign fired     = fired_q;
	assign last      = last_q;
	assign status    = out_status_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_count_q <= COUNT_BITS'(1);
			running_q      <= 1'b0;
			time_q         <= '0;
			for (int s = 0; s < NUM_TASKS; s++)
				ivl_q[s] <= '0;
			mask_q         <= '0;
			status_q       <= STS_OK;
			out_valid_q    <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready)
				active_count_q <= cfg_data;

			if (cmd.accept) begin
				mask_q   <= '0;
				status_q <= STS_OK;
				case (action_t'(in_action))
					ACT_LOAD: begin
						ivl_q[in_slot] <= in_interval;
					end
					ACT_START: begin
						if (start_bad) begin
							running_q <= 1'b0;
							status_q  <= STS_ZERO_IVL;
						end else begin
							running_q <= 1'b1;
							time_q    <= '0;
						end
					end
					ACT_STOP: begin
						running_q <= 1'b0;
					end
					ACT_TICK: begin
						if (running_q)
							time_q <= time_q + TIME_BITS'(1);
						else
							status_q <= STS_STOPPED;
					end
					default: begin
						status_q <= STS_OK;
					end
				endcase
			end else if (cmd.scan) begin
				mask_q[cmd.idx] <= is_due;
			end else if (cmd.push && !mask_empty) begin
				mask_q[lo_idx] <= 1'b0;
			end

			if (cmd.push)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start_ok) begin
			for (int s = 0; s < NUM_TASKS; s++) begin
				if (act[s])
					due_q[s] <= TIME_BITS'(ivl_q[s]);
			end
		end else if (cmd.scan && is_due) begin
			due_q[cmd.idx] <= time_q + TIME_BITS'(ivl_q[cmd.idx]);
		end

		if (cmd.push) begin
			task_id_q    <= mask_empty ? idx_t'(0) : lo_idx;
			fired_q      <= !mask_empty;
			last_q       <= mask_empty || mask_last;
			out_status_q <= status_q;
		end
	end

	a_start_refused: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.accept && in_action == ACT_START && start_bad
		|=> !running_q && status_q == STS_ZERO_IVL)
		else $error("zero interval start not refused");

	a_mask_pop: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.push && !mask_empty
		|=> $countones(mask_q) == $countones($past(mask_q)) - 1)
		else $error("emitted result did not retire exactly one slot");

	a_push_valid: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.push |=> out_valid_q)
		else $error("pushed result not presented");

endmodule

`default_nettype wire

FILE: rtl/core/periodic_task_scheduler.sv
// periodic task scheduler top level: controller, datapath and channel hookup
// load, start, stop and stopped tick go from acceptance to the emit state, which registers their word
// a running tick first scans the due state of each active slot, one slot per cycle,
// then emits one word per cycle while the response side keeps ready high
// requests: one at a time, a new one is taken only after the last word of the previous one
// reset: stopped, time zero, intervals zero, active count 1; due times unset until a start
`default_nettype none

module periodic_task_scheduler (
	input  wire logic    clk,
	input  wire logic    arst_n,
	ptsched_req_if.sink  req,
	ptsched_rsp_if.source rsp,
	ptsched_cfg_if.sink  cfg
);
	import ptsched_pkg::*;

	cmd_t cmd;
	sts_t sts;

	ptsched_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (req.valid),
		.in_action (req.action),
		.in_ready  (req.ready),
		.cmd       (cmd),
		.sts       (sts)
	);

	ptsched_dp u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.sts         (sts),
		.in_action   (req.action),
		.in_slot     (req.slot),
		.in_interval (req.interval),
		.cfg_valid   (cfg.valid),
		.cfg_ready   (cfg.ready),
		.cfg_data    (cfg.data),
		.out_valid   (rsp.valid),
		.out_ready   (rsp.ready),
		.task_id     (rsp.task_id),
		.fired       (rsp.fired),
		.last        (rsp.last),
		.status      (rsp.status)
	);

endmodule

`default_nettype wire

FILE: dv/testbench.sv
// testbench of the periodic task scheduler: predicts fired task words and checks every response
`timescale 1ns / 100ps

module testbench;
	import ptsched_pkg::*;

	localparam int HALF_PERIOD    = 5;
	localparam int RESET_CYCLES   = 5;
	localparam int WATCHDOG_LIMIT = 4000;
	localparam int SETTLE_CYCLES  = 4;
	localparam int TAIL_CYCLES    = 20;
	localparam int SEGMENTS       = 6;
	localparam int SEGMENT_ITEMS  = 73;

	typedef struct {
		logic [TASK_ID_BITS-1:0] task_id;
		logic                    fired;
		logic                    last;
		status_t                 status;
	} fire_word_t;

	class due_tracker;
		logic [TIME_BITS-1:0]     time_now;
		logic [TIME_BITS-1:0]     due_at[NUM_TASKS];
		logic [INTERVAL_BITS-1:0] period[NUM_TASKS];
		logic [NUM_TASKS-1:0]     due_set;
		bit                       running;
		logic [COUNT_BITS-1:0]    count;
		fire_word_t               due_words[$];
		int                       mismatch_count;

		function new();
			time_now = '0;
			foreach (period[i]) begin
				period[i] = '0;
				due_at[i] = '0;
			end
			due_set = '0;
			running = 0;
			count = 1;
			mismatch_count = 0;
		endfunction

		function int used();
			if (count == 0)
				return 1;
			if (count > USED_MAX)
				return USED_MAX;
			return count;
		endfunction

		// a running tick must not read a due time that no start has written
		function bit tick_defined();
			if (!running)
				return 1;
			for (int s = 0; s < used(); s++)
				if (!due_set[s])
					return 0;
			return 1;
		endfunction

		function void push_word(int id, logic fired, logic last, status_t status);
			fire_word_t w;
			w.task_id = id[TASK_ID_BITS-1:0];
			w.fired = fired;
			w.last = last;
			w.status = status;
			due_words.push_back(w);
		endfunction

		function void note_request(action_t a, logic [SLOT_BITS-1:0] s,
				logic [INTERVAL_BITS-1:0] iv);
			fire_word_t fired_now[$];
			fire_word_t w;
			int n;
			n = used();
			case (a)
				ACT_LOAD: begin
					if (s < NUM_TASKS)
						period[s] = iv;
					push_word(0, 0, 1, STS_OK);
				end
				ACT_START: begin
					for (int i = 0; i < n; i++) begin
						if (period[i] == 0) begin
							running = 0;
							push_word(0, 0, 1, STS_ZERO_IVL);
							return;
						end
					end
					time_now = '0;
					for (int i = 0; i < n; i++) begin
						due_at[i] = TIME_BITS'(period[i]);
						due_set[i] = 1'b1;
					end
					running = 1;
					push_word(0, 0, 1, STS_OK);
				end
				ACT_STOP: begin
					running = 0;
					push_word(0, 0, 1, STS_OK);
				end
				default: begin
					if (!running) begin
						push_word(0, 0, 1, STS_STOPPED);
						return;
					end
					time_now = time_now + 1'b1;
					for (int i = 0; i < n; i++) begin
						logic [TIME_BITS-1:0] lag;
						lag = time_now - due_at[i];
						if (!lag[TIME_BITS-1]) begin
							due_at[i] = time_now + TIME_BITS'(period[i]);
							w.task_id = i[TASK_ID_BITS-1:0];
							w.fired = 1'b1;
							w.last = 1'b0;
							w.status = STS_OK;
							fired_now.push_back(w);
						end
					end
					if (fired_now.size() == 0) begin
						push_word(0, 0, 1, STS_OK);
					end else begin
						fired_now[fired_now.size()-1].last = 1'b1;
						foreach (fired_now[i])
							due_words.push_back(fired_now[i]);
					end
				end
			endcase
		endfunction

		task flag(string msg);
			$display("mismatch at %0t: %s", $realtime, msg);
			mismatch_count++;
		endtask

		task check_word(fire_word_t got);
			fire_word_t want;
			if (due_words.size() == 0) begin
				flag($sformatf("unexpected word task_id %0d fired %0b last %0b status %0d",
					got.task_id, got.fired, got.last, got.status));
				return;
			end
			want = due_words.pop_front();
			if (got.task_id !== want.task_id)
				flag($sformatf("task_id %0d, want %0d", got.task_id, want.task_id));
			if (got.fired !== want.fired)
				flag($sformatf("fired %0b, want %0b", got.fired, want.fired));
			if (got.last !== want.last)
				flag($sformatf("last %0b, want %0b", got.last, want.last));
			if (got.status !== want.status)
				flag($sformatf("status %0d, want %0d", got.status, want.status));
		endtask
	endclass

	logic clk;
	logic arst_n;
	int   src_idle_pct;
	int   snk_idle_pct;
	int   items_sent;
	int   idle_run;
	fire_word_t seen_word;
	due_tracker sb = new();

	ptsched_req_if req_ch ();
	ptsched_rsp_if rsp_ch ();
	ptsched_cfg_if cfg_ch ();

	periodic_task_scheduler dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch),
		.cfg    (cfg_ch)
	);

	initial clk = 1'b0;
	always #(HALF_PERIOD) clk = ~clk;

	always @(negedge clk) begin
		rsp_ch.ready <= ($urandom_range(99) >= snk_idle_pct);
	end

	always @(posedge clk) begin
		if (arst_n === 1'b1 && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
			seen_word.task_id = rsp_ch.task_id;
			seen_word.fired = rsp_ch.fired;
			seen_word.last = rsp_ch.last;
			seen_word.status = status_t'(rsp_ch.status);
			sb.check_word(seen_word);
		end
	end

	initial begin
		idle_run = 0;
		while (idle_run < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if ((req_ch.valid === 1'b1 && req_ch.ready === 1'b1) ||
					(rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) ||
					(cfg_ch.valid === 1'b1 && cfg_ch.ready === 1'b1))
				idle_run = 0;
			else
				idle_run++;
		end
		$display("Simulation FAILED");
		$finish;
	end

	task automatic send(action_t a, logic [SLOT_BITS-1:0] s, logic [INTERVAL_BITS-1:0] iv);
		@(negedge clk);
		while ($urandom_range(99) < src_idle_pct) begin
			req_ch.valid <= 1'b0;
			@(negedge clk);
		end
		req_ch.valid <= 1'b1;
		req_ch.action <= a;
		req_ch.slot <= s;
		req_ch.interval <= iv;
		do
			@(posedge clk);
		while (req_ch.ready !== 1'b1);
		sb.note_request(a, s, iv);
		items_sent++;
	endtask

	task automatic send_tick();
		if (sb.tick_defined())
			send(ACT_TICK, SLOT_BITS'($urandom_range(7)),
				INTERVAL_BITS'($urandom_range(16'hFFFF)));
		else
			send(ACT_START, SLOT_BITS'($urandom_range(7)),
				INTERVAL_BITS'($urandom_range(16'hFFFF)));
	endtask

	task automatic wait_drain();
		@(negedge clk);
		req_ch.valid <= 1'b0;
		while (sb.due_words.size() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic write_count(logic [COUNT_BITS-1:0] v);
		wait_drain();
		cfg_ch.valid <= 1'b1;
		cfg_ch.data <= v;
		do
			@(posedge clk);
		while (cfg_ch.ready !== 1'b1);
		sb.count = v;
		@(negedge clk);
		cfg_ch.valid <= 1'b0;
	endtask

	function automatic logic [INTERVAL_BITS-1:0] pick_period();
		int r;
		r = $urandom_range(99);
		if (r < 5)
			return '0;
		if (r < 75)
			return INTERVAL_BITS'($urandom_range(1, 6));
		if (r < 90)
			return INTERVAL_BITS'($urandom_range(7, 40));
		return INTERVAL_BITS'($urandom_range(16'hFFFF));
	endfunction

	task automatic run_segment(int target);
		int r;
		int first;
		bit paused;
		action_t a;
		first = items_sent;
		paused = 0;
		while (items_sent - first < target) begin
			if (!paused && items_sent - first >= target / 2) begin
				wait_drain();
				paused = 1;
			end
			r = $urandom_range(99);
			if ((!sb.running && r < 60) || r < 6) begin
				// load every active slot, then start
				for (int s = 0; s < sb.used(); s++)
					send(ACT_LOAD, s[SLOT_BITS-1:0], pick_period());
				send(ACT_START, SLOT_BITS'($urandom_range(7)),
					INTERVAL_BITS'($urandom_range(16'hFFFF)));
			end else if (r < 72) begin
				send_tick();
			end else if (r < 80) begin
				send(ACT_LOAD, SLOT_BITS'($urandom_range(7)), pick_period());
			end else if (r < 85) begin
				send(ACT_STOP, SLOT_BITS'($urandom_range(7)),
					INTERVAL_BITS'($urandom_range(16'hFFFF)));
			end else if (r < 90) begin
				send(ACT_START, SLOT_BITS'($urandom_range(7)),
					INTERVAL_BITS'($urandom_range(16'hFFFF)));
			end else begin
				a = action_t'($urandom_range(3));
				if (a == ACT_TICK)
					send_tick();
				else
					send(a, SLOT_BITS'($urandom_range(7)),
						INTERVAL_BITS'($urandom_range(16'hFFFF)));
			end
		end
	endtask

	initial begin
		logic [COUNT_BITS-1:0] seg_count[SEGMENTS];
		seg_count = '{4'd8, 4'd1, 4'd0, 4'd15, 4'd5, 4'd9};
		seg_count[4] = COUNT_BITS'($urandom_range(2, 7));
		items_sent = 0;
		src_idle_pct = 0;
		snk_idle_pct = 0;
		arst_n <= 1'b0;
		req_ch.valid <= 1'b0;
		req_ch.action <= ACT_TICK;
		req_ch.slot <= '0;
		req_ch.interval <= '0;
		cfg_ch.valid <= 1'b0;
		cfg_ch.data <= '0;
		repeat (RESET_CYCLES) @(negedge clk);
		arst_n <= 1'b1;

		// tick while stopped, refused start, load extremes
		send(ACT_TICK, 3'd7, 16'hFFFF);
		send(ACT_START, 3'd0, 16'h0000);
		send(ACT_LOAD, 3'd0, 16'hFFFF);
		send(ACT_LOAD, 3'd7, 16'h0000);
		send(ACT_LOAD, 3'd0, 16'd1);
		send(ACT_START, 3'd0, 16'h0000);
		repeat (3) send(ACT_TICK, 3'd0, 16'h0000);
		// zero period while running fires on every tick
		send(ACT_LOAD, 3'd0, 16'h0000);
		repeat (2) send(ACT_TICK, 3'd0, 16'h0000);
		send(ACT_STOP, 3'd0, 16'h0000);
		send(ACT_TICK, 3'd0, 16'h0000);

		// all eight slots due on the same tick, then a restart
		write_count(4'd8);
		for (int s = 0; s < NUM_TASKS; s++)
			send(ACT_LOAD, s[SLOT_BITS-1:0], 16'd1);
		send(ACT_START, 3'd0, 16'h0000);
		send(ACT_TICK, 3'd0, 16'h0000);
		send(ACT_START, 3'd0, 16'h0000);
		send(ACT_TICK, 3'd0, 16'h0000);

		for (int g = 0; g < SEGMENTS; g++) begin
			if (g < 2) begin
				src_idle_pct = 15;
				snk_idle_pct = 81;
			end else if (g < 4) begin
				src_idle_pct = 81;
				snk_idle_pct = 15;
			end else begin
				src_idle_pct = 0;
				snk_idle_pct = 0;
			end
			write_count(seg_count[g]);
			run_segment(SEGMENT_ITEMS);
		end

		@(negedge clk);
		req_ch.valid <= 1'b0;
		while (sb.due_words.size() != 0)
			@(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);
		if (sb.mismatch_count == 0 && sb.due_words.size() == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule
